FILE: design/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// shared types, codes and character helpers of the integer to ascii formatter
// ----------------------------------------------------------------------------
package itaf_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_SDEC  = 3'd0;
    localparam op_t OP_UDEC  = 3'd1;
    localparam op_t OP_HEXL  = 3'd2;
    localparam op_t OP_HEXU  = 3'd3;
    localparam op_t OP_PTR   = 3'd4;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWER  = 8'h61;
    localparam logic [7:0] CH_UPPER  = 8'h41;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6c;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam int DEC_BITS   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int HEX_DIGITS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_PREFIX,
        ST_DIGITS
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } prefix_t;

    function automatic logic [2:0] prefix_len(input prefix_t kind);
        case (kind)
            PFX_NONE:  prefix_len = 3'd0;
            PFX_MINUS: prefix_len = 3'd1;
            PFX_HEX:   prefix_len = 3'd2;
            PFX_NIL:   prefix_len = 3'd5;
            default:   prefix_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input prefix_t kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_ZERO;
        case (kind)
            PFX_MINUS: ch = CH_MINUS;
            PFX_HEX:   ch = (idx == 3'd0) ? CH_ZERO : CH_X;
            PFX_NIL:
            begin
                case (idx)
                    3'd0:    ch = CH_LPAREN;
                    3'd1:    ch = CH_N;
                    3'd2:    ch = CH_I;
                    3'd3:    ch = CH_L;
                    default: ch = CH_RPAREN;
                endcase
            end
            default:   ch = CH_ZERO;
        endcase
        prefix_char = ch;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER : CH_LOWER;
        if (d > 4'd9)
        begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
        else
        begin
            digit_char = CH_ZERO + {4'd0, d};
        end
    endfunction

endpackage

FILE: design/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// formats one integer as ascii text (signed/unsigned decimal, hex, pointer)
// ----------------------------------------------------------------------------
// decimal requests turn the low 32 bits into bcd by shift-add-3, then skip
// leading zeros and give one character per cycle while the output is not
// stalled (up to 11); hex and non-nil pointer requests skip only the zeros
// before their up to 18 characters; one request is worked at a time
// throughput is set by the single shift/adjust unit and the serial output
// reset: rst_n clears the sequencer and the output valid, block comes up idle
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // character[7:0], char_count[12:8], zero[15:13]
    output logic        m_tlast    // is_last
);

    itaf_pkg::state_t  state_reg, state_next;
    itaf_pkg::prefix_t pfx_reg, pfx_next;
    logic [63:0] digits_reg, digits_next;
    logic [31:0] bin_reg, bin_next;
    logic [4:0]  bit_cnt_reg, bit_cnt_next;
    logic [4:0]  left_reg, left_next;
    logic [4:0]  count_reg, count_next;
    logic [2:0]  pidx_reg, pidx_next;
    logic        upper_reg, upper_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  char_reg, char_next;
    logic [4:0]  ccount_reg, ccount_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic        accept;
    logic        conv_done;
    logic        skip_done;
    logic        pfx_last;
    logic        digit_last;
    logic [31:0] lo_word;
    logic [31:0] neg_word;
    logic [39:0] bcd_adj;
    logic [2:0]  pfx_len;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == itaf_pkg::ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign lo_word    = s_tdata[31:0];
    assign neg_word   = ~lo_word + 32'd1;
    assign conv_done  = (bit_cnt_reg == 5'(itaf_pkg::DEC_BITS - 1));
    assign skip_done  = (digits_reg[63:60] != 4'd0) || (left_reg == 5'd1);
    assign pfx_len    = itaf_pkg::prefix_len(pfx_reg);
    assign pfx_last   = (pidx_reg == pfx_len - 3'd1);
    assign digit_last = (left_reg == 5'd1);

    // shift-add-3 correction, digits are independent
    always_comb
    begin
        for (int i = 0; i < itaf_pkg::BCD_DIGITS; i++)
        begin
            if (digits_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = digits_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = digits_reg[4*i +: 4];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        itaf_pkg::OP_SDEC, itaf_pkg::OP_UDEC:
                            state_next = itaf_pkg::ST_CONVERT;
                        itaf_pkg::OP_HEXL, itaf_pkg::OP_HEXU:
                            state_next = itaf_pkg::ST_SKIP;
                        itaf_pkg::OP_PTR:
                            state_next = (s_tdata == 64'd0) ? itaf_pkg::ST_PREFIX
                                                            : itaf_pkg::ST_SKIP;
                        default:
                            state_next = itaf_pkg::ST_IDLE;
                    endcase
                end
            end
            itaf_pkg::ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = itaf_pkg::ST_SKIP;
                end
            end
            itaf_pkg::ST_SKIP:
            begin
                if (skip_done)
                begin
                    state_next = (pfx_reg == itaf_pkg::PFX_NONE) ? itaf_pkg::ST_DIGITS
                                                                 : itaf_pkg::ST_PREFIX;
                end
            end
            itaf_pkg::ST_PREFIX:
            begin
                if (out_free && pfx_last)
                begin
                    state_next = (pfx_reg == itaf_pkg::PFX_NIL) ? itaf_pkg::ST_IDLE
                                                                : itaf_pkg::ST_DIGITS;
                end
            end
            itaf_pkg::ST_DIGITS:
            begin
                if (out_free && digit_last)
                begin
                    state_next = itaf_pkg::ST_IDLE;
                end
            end
            default:
                state_next = itaf_pkg::ST_IDLE;
        endcase
    end

    // datapath and output
    always_comb
    begin
        pfx_next      = pfx_reg;
        digits_next   = digits_reg;
        bin_next      = bin_reg;
        bit_cnt_next  = bit_cnt_reg;
        left_next     = left_reg;
        count_next    = count_reg;
        pidx_next     = pidx_reg;
        upper_next    = upper_reg;
        char_next     = char_reg;
        ccount_next   = ccount_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                bit_cnt_next = 5'd0;
                left_next    = 5'(itaf_pkg::HEX_DIGITS);
                count_next   = 5'd0;
                pidx_next    = 3'd0;
                upper_next   = (s_tuser == itaf_pkg::OP_HEXU);
                digits_next  = s_tdata;
                bin_next     = lo_word;
                pfx_next     = itaf_pkg::PFX_NONE;
                case (s_tuser)
                    itaf_pkg::OP_SDEC:
                    begin
                        digits_next = 64'd0;
                        if (lo_word[31])
                        begin
                            bin_next = neg_word;
                            pfx_next = itaf_pkg::PFX_MINUS;
                        end
                    end
                    itaf_pkg::OP_UDEC:
                        digits_next = 64'd0;
                    itaf_pkg::OP_PTR:
                        pfx_next = (s_tdata == 64'd0) ? itaf_pkg::PFX_NIL : itaf_pkg::PFX_HEX;
                    default:
                        pfx_next = itaf_pkg::PFX_NONE;
                endcase
            end
            itaf_pkg::ST_CONVERT:
            begin
                digits_next  = {24'd0, bcd_adj[38:0], bin_reg[31]};
                bin_next     = {bin_reg[30:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
            end
            itaf_pkg::ST_SKIP:
            begin
                if (!skip_done)
                begin
                    digits_next = {digits_reg[59:0], 4'd0};
                    left_next   = left_reg - 5'd1;
                end
            end
            itaf_pkg::ST_PREFIX:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    char_next     = itaf_pkg::prefix_char(pfx_reg, pidx_reg);
                    last_next     = pfx_last && (pfx_reg == itaf_pkg::PFX_NIL);
                    ccount_next   = last_next ? (count_reg + 5'd1) : 5'd0;
                    count_next    = count_reg + 5'd1;
                    pidx_next     = pidx_reg + 3'd1;
                end
            end
            itaf_pkg::ST_DIGITS:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    char_next     = itaf_pkg::digit_char(digits_reg[63:60], upper_reg);
                    last_next     = digit_last;
                    ccount_next   = digit_last ? (count_reg + 5'd1) : 5'd0;
                    count_next    = count_reg + 5'd1;
                    digits_next   = {digits_reg[59:0], 4'd0};
                    left_next     = left_reg - 5'd1;
                end
            end
            default:
                m_tvalid_next = m_tvalid_reg && !m_tready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= itaf_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pfx_reg     <= pfx_next;
        digits_reg  <= digits_next;
        bin_reg     <= bin_next;
        bit_cnt_reg <= bit_cnt_next;
        left_reg    <= left_next;
        count_reg   <= count_next;
        pidx_reg    <= pidx_next;
        upper_reg   <= upper_next;
        char_reg    <= char_next;
        ccount_reg  <= ccount_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, ccount_reg, char_reg};
    assign m_tlast  = last_reg;

    a_last_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[12:8] != 5'd0) && (m_tdata[12:8] <= 5'd18))
        else $error("last character without a valid count");

    a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[12:8] == 5'd0))
        else $error("count on a character that is not last");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itaf_pkg::ST_SKIP) || (state_reg == itaf_pkg::ST_DIGITS)
        |-> (left_reg != 5'd0) && (left_reg <= 5'(itaf_pkg::HEX_DIGITS)))
        else $error("digit counter out of range");

    a_convert_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itaf_pkg::ST_CONVERT) && conv_done |=> (state_reg == itaf_pkg::ST_SKIP))
        else $error("conversion did not hand over to skip");

endmodule

FILE: tb/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker
// watches both stream channels of the formatter, predicts the text of every
// accepted request and compares each output character, its last flag, its
// count and its zero pad bits in order
// ----------------------------------------------------------------------------
module itaf_checker
    import itaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          requests,
    output int          dropped,
    output int          chars
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [4:0] count;
    } text_char_t;

    text_char_t text_q[$];
    int         err_n;
    int         req_n;
    int         drop_n;
    int         char_n;

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        err_n++;
        if (err_n <= 40)
        begin
            $display("mismatch at character %0d: %s got 0x%02h expected 0x%02h",
                     char_n, field, got, want);
        end
    endtask

    function automatic void queue_text(input op_t op, input logic [63:0] value);
        logic [7:0]  txt [0:17];
        logic [7:0]  rev [0:19];
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] digit;
        logic [7:0]  letter;
        logic        nil_text;
        text_char_t  item;
        int          len;
        int          n;
        len      = 0;
        n        = 0;
        radix    = 64'd16;
        letter   = CH_LOWER;
        mag      = value;
        nil_text = 1'b0;
        case (op)
            OP_SDEC:
            begin
                radix = 64'd10;
                mag   = {32'd0, value[31:0]};
                if (value[31])
                begin
                    txt[len] = CH_MINUS;
                    len++;
                    mag = {32'd0, -value[31:0]};
                end
            end
            OP_UDEC:
            begin
                radix = 64'd10;
                mag   = {32'd0, value[31:0]};
            end
            OP_HEXL:
            begin
                letter = CH_LOWER;
            end
            OP_HEXU:
            begin
                letter = CH_UPPER;
            end
            OP_PTR:
            begin
                if (value == 64'd0)
                begin
                    nil_text = 1'b1;
                    txt[0]   = CH_LPAREN;
                    txt[1]   = CH_N;
                    txt[2]   = CH_I;
                    txt[3]   = CH_L;
                    txt[4]   = CH_RPAREN;
                    len      = 5;
                end
                else
                begin
                    txt[0] = CH_ZERO;
                    txt[1] = CH_X;
                    len    = 2;
                end
            end
            default:
            begin
                return;
            end
        endcase
        if (!nil_text)
        begin
            do
            begin
                digit  = mag % radix;
                mag    = mag / radix;
                rev[n] = (digit > 64'd9) ? letter + digit[7:0] - 8'd10 : CH_ZERO + digit[7:0];
                n++;
            end
            while (mag != 64'd0);
            while (n > 0)
            begin
                n--;
                txt[len] = rev[n];
                len++;
            end
        end
        for (int k = 0; k < len; k++)
        begin
            item.ch    = txt[k];
            item.last  = (k == len - 1);
            item.count = (k == len - 1) ? len[4:0] : 5'd0;
            text_q.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (text_q.size() == 0)
                begin
                    report_mismatch("unexpected character", m_tdata[7:0], 8'h00);
                end
                else
                begin
                    want = text_q.pop_front();
                    if (m_tdata[7:0] != want.ch)
                    begin
                        report_mismatch("character", m_tdata[7:0], want.ch);
                    end
                    if (m_tlast != want.last)
                    begin
                        report_mismatch("last flag", {7'd0, m_tlast}, {7'd0, want.last});
                    end
                    if (m_tdata[12:8] != want.count)
                    begin
                        report_mismatch("count", {3'd0, m_tdata[12:8]}, {3'd0, want.count});
                    end
                    if (m_tdata[15:13] != 3'd0)
                    begin
                        report_mismatch("pad bits", {5'd0, m_tdata[15:13]}, 8'h00);
                    end
                end
                char_n++;
            end
            if (s_tvalid && s_tready)
            begin
                req_n++;
                if (s_tuser > OP_PTR)
                begin
                    drop_n++;
                end
                queue_text(s_tuser, s_tdata);
            end
        end
        errors   <= err_n;
        pending  <= text_q.size();
        requests <= req_n;
        dropped  <= drop_n;
        chars    <= char_n;
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives requests of every conversion into the integer to ascii formatter,
// with random idle cycles on both sides, a long output stall and a stretch
// without idling; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module testbench;
    import itaf_pkg::*;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  HOLD_CYCLES   = 500;
    localparam int  SETTLE_CYCLES = 80;
    localparam op_t OP_UNUSED_HI  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int errors;
    int pending;
    int requests;
    int dropped;
    int chars;
    int cycles;
    bit steady;
    int hold_ask;
    int hold_taken;
    int hold_left;

    integer_to_ascii_formatter_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itaf_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending),
        .requests (requests),
        .dropped  (dropped),
        .chars    (chars)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding", cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side: random back-pressure, or a long hold when asked
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_taken != hold_ask)
            begin
                hold_taken = hold_ask;
                hold_left  = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    task automatic send_request(input op_t op, input logic [63:0] value);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          width;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = 64'd0;
            1:       v = '1;
            2:       v = 64'd1 << $urandom_range(0, 63);
            3:       v = {v[63:32], ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff};
            4, 5, 6:
            begin
                width = $urandom_range(1, 63);
                v     = v & ((64'd1 << width) - 64'd1);
            end
            default: v = v;
        endcase
        return v;
    endfunction

    task automatic random_requests(input int count);
        op_t op;
        int  done_n;
        done_n = 0;
        while (done_n < count)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                op = op_t'($urandom_range(int'(OP_PTR) + 1, int'(OP_UNUSED_HI)));
            end
            else
            begin
                op = op_t'($urandom_range(int'(OP_SDEC), int'(OP_PTR)));
                done_n++;
            end
            send_request(op, random_value());
        end
    endtask

    initial
    begin
        s_tvalid <= 1'b0;
        s_tdata  <= 64'd0;
        s_tuser  <= OP_SDEC;
        rst_n    <= 1'b0;
        steady    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, extremes, the most negative 32-bit value and the unused selectors
        send_request(OP_SDEC, 64'd0);
        send_request(OP_SDEC, 64'h0000_0000_8000_0000);
        send_request(OP_SDEC, 64'hdead_beef_ffff_ffff);
        send_request(OP_SDEC, 64'hffff_ffff_7fff_ffff);
        send_request(OP_SDEC, 64'h0000_0000_c465_3600);
        send_request(OP_UDEC, 64'd0);
        send_request(OP_UDEC, 64'hffff_ffff_ffff_ffff);
        send_request(OP_UDEC, 64'd1000000000);
        send_request(OP_UDEC, 64'd9);
        send_request(OP_HEXL, 64'd0);
        send_request(OP_HEXL, 64'hffff_ffff_ffff_ffff);
        send_request(OP_HEXL, 64'h0123_4567_89ab_cdef);
        send_request(OP_HEXU, 64'd0);
        send_request(OP_HEXU, 64'hfedc_ba98_7654_3210);
        send_request(OP_HEXU, 64'h0000_0000_0000_000a);
        send_request(OP_PTR, 64'd0);
        send_request(OP_PTR, 64'hffff_ffff_ffff_ffff);
        send_request(OP_PTR, 64'd1);
        send_request(OP_PTR, 64'h8000_0000_0000_0000);
        send_request(op_t'(int'(OP_PTR) + 1), 64'h1234_5678_9abc_def0);
        send_request(OP_UNUSED_HI, 64'd0);
        send_request(op_t'(int'(OP_PTR) + 2), 64'hffff_ffff_ffff_ffff);
        drain_results();

        random_requests(130);
        drain_results();

        // long output stall with the input kept busy, then no idling at all
        steady = 1'b1;
        hold_ask++;
        random_requests(120);
        steady = 1'b0;
        drain_results();

        random_requests(140);
        drain_results();

        $display("covered %0d requests (%0d with unused selectors), %0d characters checked",
                 requests, dropped, chars);
        $display("included all conversions, their extremes, a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
design/itaf_pkg.sv
design/integer_to_ascii_formatter_core.sv
tb/itaf_checker.sv
tb/testbench.sv
